// ===== src/pte_pkg.sv =====
`default_nettype none
package pte_pkg;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam int DEF_NUM_COLS = 512;
    localparam int DEF_NUM_ROWS = 256;

    localparam int COL_W  = 9;
    localparam int ROW_W  = 8;
    localparam int TOT_W  = 14;
    localparam int A_W    = 24;
    localparam int B_W    = 20;
    localparam int C_W    = 24;
    localparam int T_W    = 16;
    localparam int E_W    = 24;
    localparam int COEF_W = A_W + B_W + C_W + T_W;

    localparam int D_W    = 44;
    localparam int RAD_W  = 88;
    localparam int SQ_N   = 44;
    localparam int REM_W  = 47;
    localparam int NUM_W  = 46;
    localparam int DVD_W  = 47;
    localparam int DEN_W  = 25;
    localparam int DIV_N  = 25;
    localparam int CMP_W  = 50;

    localparam logic signed [E_W-1:0] E_MAX = 24'sh7FFFFF;
    localparam logic signed [E_W-1:0] E_MIN = 24'sh800000;

endpackage
`default_nettype wire

// ===== src/pixel_tot_to_energy.sv =====
// pixel_tot_to_energy: per-pixel time-over-threshold to energy conversion
//
// input channel: in_valid / in_ready with opcode, pixel_col, pixel_row,
// tot_count and the four coefficients. a write beat (opcode 0) stores one
// pixel's coefficients and gives no result; a convert beat (opcode 1) gives
// one result beat on out_valid / out_ready carrying energy and invalid.
// one beat is taken every cycle while in_ready is high; a convert result
// passes through the table read, the products and the discriminant, the
// bit-per-stage square root, the numerator and the bit-per-stage divider,
// then the output register.
// a convert may follow a write to the same pixel in the very next cycle.
// reset clears all valid bits and the output side; table contents are
// undefined until written. when the receiver stalls, one more result is
// held in a skid register and the whole pipeline then freezes, with
// in_ready low, until the output register is free again; nothing is lost.
`default_nettype none
module pixel_tot_to_energy
    import pte_pkg::*;
#(
    parameter int NUM_COLS = DEF_NUM_COLS,
    parameter int NUM_ROWS = DEF_NUM_ROWS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    opcode,
    input  wire logic [COL_W-1:0]        pixel_col,
    input  wire logic [ROW_W-1:0]        pixel_row,
    input  wire logic [TOT_W-1:0]        tot_count,
    input  wire logic [A_W-1:0]          coef_a,
    input  wire logic signed [B_W-1:0]   coef_b,
    input  wire logic signed [C_W-1:0]   coef_c,
    input  wire logic signed [T_W-1:0]   coef_t,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [E_W-1:0]        energy,
    output logic                         invalid
);

    localparam int NUM_PIX = NUM_COLS * NUM_ROWS;
    localparam int ADDR_W  = (NUM_PIX > 1) ? $clog2(NUM_PIX) : 1;

    logic [COEF_W-1:0] mem [0:NUM_PIX-1];

    logic out_valid_reg, skid_full_reg;
    logic adv;
    logic in_fire;
    logic in_range;
    logic [ADDR_W-1:0] addr;

    assign adv      = !skid_full_reg;
    assign in_ready = adv;
    assign in_fire  = in_valid && in_ready;
    assign in_range = (32'(pixel_col) < 32'(NUM_COLS)) && (32'(pixel_row) < 32'(NUM_ROWS));
    assign addr     = ADDR_W'(32'(pixel_row) * 32'(NUM_COLS) + 32'(pixel_col));

    // stage 1: table read
    logic              v1_reg, bad1_reg;
    logic [TOT_W-1:0]  tot1_reg;
    logic [COEF_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && opcode == OP_WRITE && in_range)
        begin
            mem[addr] <= {coef_a, coef_b, coef_c, coef_t};
        end
        if (adv)
        begin
            rd_reg <= mem[addr];
        end
    end

    // stage 2: products
    logic [A_W-1:0]          a_w;
    logic signed [B_W-1:0]   b_w;
    logic signed [C_W-1:0]   c_w;
    logic signed [T_W-1:0]   t_w;
    logic signed [40:0]      ta_w;
    logic signed [48:0]      ac_w;

    assign a_w  = rd_reg[COEF_W-1 -: A_W];
    assign b_w  = rd_reg[C_W+T_W+B_W-1 -: B_W];
    assign c_w  = rd_reg[T_W+C_W-1 -: C_W];
    assign t_w  = rd_reg[T_W-1:0];
    assign ta_w = $signed(t_w) * $signed({1'b0, a_w});
    assign ac_w = $signed(c_w) * $signed({1'b0, a_w});

    logic                   v2_reg, bad2_reg;
    logic [A_W-1:0]         a2_reg;
    logic signed [40:0]     ta2_reg;
    logic signed [48:0]     ac2_reg;
    logic signed [B_W-1:0]  b2_reg;
    logic [TOT_W-1:0]       tot2_reg;

    // stage 3: d, p and |ac|
    logic signed [D_W-1:0] d_w, p_w, b16_w, tot24_w;
    logic [47:0]           acmag_w;

    assign b16_w   = D_W'(b2_reg) <<< 16;
    assign tot24_w = $signed({6'b0, tot2_reg, 24'b0});
    assign d_w     = D_W'(ta2_reg) + b16_w - tot24_w;
    assign p_w     = D_W'(ta2_reg) - b16_w + tot24_w;
    assign acmag_w = ac2_reg[48] ? 48'(-ac2_reg) : 48'(ac2_reg);

    logic                   v3_reg, bad3_reg, neg3_reg;
    logic [A_W-1:0]         a3_reg;
    logic signed [D_W-1:0]  d3_reg, p3_reg;
    logic [47:0]            acm3_reg;

    // stage 4: partial products of d*d
    logic [42:0] dmag_w;
    assign dmag_w = d3_reg[D_W-1] ? 43'(-d3_reg) : 43'(d3_reg);

    logic                   v4_reg, bad4_reg, neg4_reg;
    logic [A_W-1:0]         a4_reg;
    logic signed [D_W-1:0]  p4_reg;
    logic [47:0]            acm4_reg;
    logic [43:0]            hh4_reg;
    logic [42:0]            hl4_reg;
    logic [41:0]            ll4_reg;

    // stage 5: d*d and 4ac scaled
    logic                   v5_reg, bad5_reg, neg5_reg;
    logic [A_W-1:0]         a5_reg;
    logic signed [D_W-1:0]  p5_reg;
    logic [RAD_W-1:0]       sq5_reg, term5_reg;

    // stage 6: discriminant
    logic                   v6_reg, bad6_reg;
    logic [A_W-1:0]         a6_reg;
    logic signed [D_W-1:0]  p6_reg;
    logic [RAD_W-1:0]       disc6_reg;

    // square root, one root bit per stage
    logic                   sq_v_reg   [0:SQ_N-1];
    logic                   sq_bad_reg [0:SQ_N-1];
    logic [A_W-1:0]         sq_a_reg   [0:SQ_N-1];
    logic signed [D_W-1:0]  sq_p_reg   [0:SQ_N-1];
    logic [RAD_W-1:0]       sq_rad_reg [0:SQ_N-1];
    logic [REM_W-1:0]       sq_rem_reg [0:SQ_N-1];
    logic [SQ_N-1:0]        sq_root_reg[0:SQ_N-1];

    logic [RAD_W-1:0]  sq_rad_next [0:SQ_N-1];
    logic [REM_W-1:0]  sq_rem_next [0:SQ_N-1];
    logic [SQ_N-1:0]   sq_root_next[0:SQ_N-1];

    always_comb
    begin
        logic [RAD_W-1:0] rad_in;
        logic [REM_W-1:0] rem_in, rem_sh, trial;
        logic [SQ_N-1:0]  root_in;
        for (int i = 0; i < SQ_N; i++)
        begin
            if (i == 0)
            begin
                rad_in  = disc6_reg;
                rem_in  = '0;
                root_in = '0;
            end
            else
            begin
                rad_in  = sq_rad_reg[(i > 0) ? i - 1 : 0];
                rem_in  = sq_rem_reg[(i > 0) ? i - 1 : 0];
                root_in = sq_root_reg[(i > 0) ? i - 1 : 0];
            end
            rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial  = {1'b0, root_in, 2'b01};
            sq_rad_next[i] = rad_in << 2;
            if (rem_sh >= trial)
            begin
                sq_rem_next[i]  = rem_sh - trial;
                sq_root_next[i] = {root_in[SQ_N-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[i]  = rem_sh;
                sq_root_next[i] = {root_in[SQ_N-2:0], 1'b0};
            end
        end
    end

    // numerator and rounding offset
    logic signed [NUM_W-1:0] num_w;
    assign num_w = NUM_W'(sq_p_reg[SQ_N-1]) + $signed({2'b0, sq_root_reg[SQ_N-1]});

    logic                    n1_v_reg, n1_bad_reg;
    logic [A_W-1:0]          n1_a_reg;
    logic signed [NUM_W-1:0] n1_num_reg;

    logic [NUM_W-1:0] nabs_w;
    assign nabs_w = n1_num_reg[NUM_W-1] ? NUM_W'(-n1_num_reg) : NUM_W'(n1_num_reg);

    logic              n2_v_reg, n2_bad_reg, n2_neg_reg;
    logic [DVD_W-1:0]  n2_dvd_reg;
    logic [DEN_W-1:0]  n2_den_reg;

    logic              n3_v_reg, n3_bad_reg, n3_neg_reg, n3_ovf_reg;
    logic [DVD_W-1:0]  n3_dvd_reg;
    logic [DEN_W-1:0]  n3_den_reg;

    // divider, one quotient bit per stage
    logic              dv_v_reg   [0:DIV_N-1];
    logic              dv_bad_reg [0:DIV_N-1];
    logic              dv_neg_reg [0:DIV_N-1];
    logic              dv_ovf_reg [0:DIV_N-1];
    logic [DEN_W-1:0]  dv_den_reg [0:DIV_N-1];
    logic [DVD_W-1:0]  dv_rem_reg [0:DIV_N-1];
    logic [DIV_N-1:0]  dv_q_reg   [0:DIV_N-1];

    logic [DVD_W-1:0]  dv_rem_next[0:DIV_N-1];
    logic [DIV_N-1:0]  dv_q_next  [0:DIV_N-1];

    always_comb
    begin
        logic [DVD_W-1:0] rem_in;
        logic [DIV_N-1:0] q_in;
        logic [DEN_W-1:0] den_in;
        logic [CMP_W-1:0] den_sh;
        for (int j = 0; j < DIV_N; j++)
        begin
            if (j == 0)
            begin
                rem_in = n3_dvd_reg;
                q_in   = '0;
                den_in = n3_den_reg;
            end
            else
            begin
                rem_in = dv_rem_reg[(j > 0) ? j - 1 : 0];
                q_in   = dv_q_reg[(j > 0) ? j - 1 : 0];
                den_in = dv_den_reg[(j > 0) ? j - 1 : 0];
            end
            den_sh = CMP_W'(den_in) << (DIV_N - 1 - j);
            if (CMP_W'(rem_in) >= den_sh)
            begin
                dv_rem_next[j] = DVD_W'(CMP_W'(rem_in) - den_sh);
                dv_q_next[j]   = q_in | (DIV_N'(1) << (DIV_N - 1 - j));
            end
            else
            begin
                dv_rem_next[j] = rem_in;
                dv_q_next[j]   = q_in;
            end
        end
    end

    // saturation
    logic [DIV_N-1:0]       nmag_w;
    logic signed [E_W-1:0]  res_e_w;
    logic                   res_v_w, res_bad_w;

    assign res_v_w   = dv_v_reg[DIV_N-1];
    assign res_bad_w = dv_bad_reg[DIV_N-1];
    assign nmag_w    = dv_ovf_reg[DIV_N-1] ? (DIV_N'(1) << (DIV_N - 1)) : dv_q_reg[DIV_N-1];

    always_comb
    begin
        if (res_bad_w)
        begin
            res_e_w = '0;
        end
        else if (!dv_neg_reg[DIV_N-1])
        begin
            res_e_w = (nmag_w > DIV_N'(E_MAX)) ? E_MAX : $signed(nmag_w[E_W-1:0]);
        end
        else
        begin
            res_e_w = (nmag_w >= DIV_N'(1) << (E_W - 1)) ? E_MIN
                                                        : $signed(-nmag_w[E_W-1:0]);
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            n1_v_reg <= 1'b0;
            n2_v_reg <= 1'b0;
            n3_v_reg <= 1'b0;
            for (int i = 0; i < SQ_N; i++)
            begin
                sq_v_reg[i] <= 1'b0;
            end
            for (int j = 0; j < DIV_N; j++)
            begin
                dv_v_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg   <= in_fire && opcode == OP_CONVERT;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            sq_v_reg[0] <= v6_reg;
            for (int i = 1; i < SQ_N; i++)
            begin
                sq_v_reg[i] <= sq_v_reg[i-1];
            end
            n1_v_reg <= sq_v_reg[SQ_N-1];
            n2_v_reg <= n1_v_reg;
            n3_v_reg <= n2_v_reg;
            dv_v_reg[0] <= n3_v_reg;
            for (int j = 1; j < DIV_N; j++)
            begin
                dv_v_reg[j] <= dv_v_reg[j-1];
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bad1_reg <= !in_range;
            tot1_reg <= tot_count;

            bad2_reg <= bad1_reg || (a_w == '0);
            a2_reg   <= a_w;
            ta2_reg  <= ta_w;
            ac2_reg  <= ac_w;
            b2_reg   <= b_w;
            tot2_reg <= tot1_reg;

            bad3_reg <= bad2_reg;
            neg3_reg <= ac2_reg[48];
            a3_reg   <= a2_reg;
            d3_reg   <= d_w;
            p3_reg   <= p_w;
            acm3_reg <= acmag_w;

            bad4_reg <= bad3_reg;
            neg4_reg <= neg3_reg;
            a4_reg   <= a3_reg;
            p4_reg   <= p3_reg;
            acm4_reg <= acm3_reg;
            hh4_reg  <= 44'(dmag_w[42:21]) * 44'(dmag_w[42:21]);
            hl4_reg  <= 43'(dmag_w[42:21]) * 43'(dmag_w[20:0]);
            ll4_reg  <= 42'(dmag_w[20:0]) * 42'(dmag_w[20:0]);

            bad5_reg  <= bad4_reg;
            neg5_reg  <= neg4_reg;
            a5_reg    <= a4_reg;
            p5_reg    <= p4_reg;
            sq5_reg   <= (RAD_W'(hh4_reg) << 42) + (RAD_W'(hl4_reg) << 22) + RAD_W'(ll4_reg);
            term5_reg <= RAD_W'(acm4_reg) << 26;

            bad6_reg  <= bad5_reg || (neg5_reg && sq5_reg < term5_reg);
            a6_reg    <= a5_reg;
            p6_reg    <= p5_reg;
            disc6_reg <= neg5_reg ? sq5_reg - term5_reg : sq5_reg + term5_reg;

            for (int i = 0; i < SQ_N; i++)
            begin
                sq_bad_reg[i]  <= (i == 0) ? bad6_reg : sq_bad_reg[(i > 0) ? i - 1 : 0];
                sq_a_reg[i]    <= (i == 0) ? a6_reg : sq_a_reg[(i > 0) ? i - 1 : 0];
                sq_p_reg[i]    <= (i == 0) ? p6_reg : sq_p_reg[(i > 0) ? i - 1 : 0];
                sq_rad_reg[i]  <= sq_rad_next[i];
                sq_rem_reg[i]  <= sq_rem_next[i];
                sq_root_reg[i] <= sq_root_next[i];
            end

            n1_bad_reg <= sq_bad_reg[SQ_N-1];
            n1_a_reg   <= sq_a_reg[SQ_N-1];
            n1_num_reg <= num_w;

            n2_bad_reg <= n1_bad_reg;
            n2_neg_reg <= n1_num_reg[NUM_W-1];
            n2_dvd_reg <= DVD_W'(nabs_w) + DVD_W'(n1_a_reg);
            n2_den_reg <= {n1_a_reg, 1'b0};

            n3_bad_reg <= n2_bad_reg;
            n3_neg_reg <= n2_neg_reg;
            n3_ovf_reg <= CMP_W'(n2_dvd_reg) >= (CMP_W'(n2_den_reg) << DIV_N);
            n3_dvd_reg <= n2_dvd_reg;
            n3_den_reg <= n2_den_reg;

            for (int j = 0; j < DIV_N; j++)
            begin
                dv_bad_reg[j] <= (j == 0) ? n3_bad_reg : dv_bad_reg[(j > 0) ? j - 1 : 0];
                dv_neg_reg[j] <= (j == 0) ? n3_neg_reg : dv_neg_reg[(j > 0) ? j - 1 : 0];
                dv_ovf_reg[j] <= (j == 0) ? n3_ovf_reg : dv_ovf_reg[(j > 0) ? j - 1 : 0];
                dv_den_reg[j] <= (j == 0) ? n3_den_reg : dv_den_reg[(j > 0) ? j - 1 : 0];
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
            end
        end
    end

    // output register and skid
    logic signed [E_W-1:0] out_e_reg, skid_e_reg;
    logic                  out_bad_reg, skid_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= skid_full_reg || res_v_w;
            skid_full_reg <= 1'b0;
        end
        else if (res_v_w && adv)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_e_reg   <= skid_full_reg ? skid_e_reg : res_e_w;
            out_bad_reg <= skid_full_reg ? skid_bad_reg : res_bad_w;
        end
        else if (res_v_w && adv)
        begin
            skid_e_reg   <= res_e_w;
            skid_bad_reg <= res_bad_w;
        end
    end

    assign out_valid = out_valid_reg;
    assign energy    = out_e_reg;
    assign invalid   = out_bad_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds a beat while output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without a stalled output");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && invalid) |-> (energy == '0))
        else $error("invalid result with nonzero energy");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && opcode == OP_WRITE) |=> !v1_reg)
        else $error("write beat entered the conversion pipeline");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top
    import pte_pkg::*;
();

    typedef struct packed {
        logic                  op;
        logic [COL_W-1:0]      col;
        logic [ROW_W-1:0]      row;
        logic [TOT_W-1:0]      tot;
        logic [A_W-1:0]        a;
        logic signed [B_W-1:0] b;
        logic signed [C_W-1:0] c;
        logic signed [T_W-1:0] t;
    } pixel_beat_t;

    typedef struct packed {
        logic signed [E_W-1:0] energy;
        logic                  invalid;
    } energy_beat_t;

    localparam int N_RANDOM = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic opcode = OP_WRITE;
    logic [COL_W-1:0] pixel_col = '0;
    logic [ROW_W-1:0] pixel_row = '0;
    logic [TOT_W-1:0] tot_count = '0;
    logic [A_W-1:0] coef_a = '0;
    logic signed [B_W-1:0] coef_b = '0;
    logic signed [C_W-1:0] coef_c = '0;
    logic signed [T_W-1:0] coef_t = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [E_W-1:0] energy;
    logic invalid;

    pixel_beat_t  beat_queue[$];
    energy_beat_t energy_queue[$];
    logic [A_W-1:0]        slope_mem[int];
    logic signed [B_W-1:0] offset_mem[int];
    logic signed [C_W-1:0] curve_mem[int];
    logic signed [T_W-1:0] asym_mem[int];
    int  written_pix[$];
    bit  written_seen[int];
    int  beats_taken = 0;
    int  total_beats = 0;
    int  mismatches = 0;
    int  hold_count = 0;
    bit  hold_done = 1'b0;

    pixel_tot_to_energy u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .pixel_col(pixel_col), .pixel_row(pixel_row),
        .tot_count(tot_count), .coef_a(coef_a), .coef_b(coef_b),
        .coef_c(coef_c), .coef_t(coef_t),
        .out_valid(out_valid), .out_ready(out_ready),
        .energy(energy), .invalid(invalid)
    );

    always #10 clk = ~clk;

    function automatic energy_beat_t calc_energy(int idx, logic [TOT_W-1:0] tot);
        energy_beat_t res;
        longint a, b, c, t, d, p, ac4, num;
        logic [63:0] dmag, acmag, nmag, root, cand;
        logic [127:0] sq, term, disc;
        res.energy = '0;
        res.invalid = 1'b1;
        a = longint'(slope_mem[idx]);
        b = longint'(offset_mem[idx]);
        c = longint'(curve_mem[idx]);
        t = longint'(asym_mem[idx]);
        d = t * a + b * 65536 - (longint'(tot) <<< 24);
        p = t * a - b * 65536 + (longint'(tot) <<< 24);
        dmag = d < 0 ? -d : d;
        ac4 = 4 * a * c;
        acmag = ac4 < 0 ? -ac4 : ac4;
        if (a == 0)
            return res;
        sq = {64'b0, dmag} * {64'b0, dmag};
        term = {64'b0, acmag} << 24;
        if (ac4 < 0)
        begin
            if (sq < term)
                return res;
            disc = sq - term;
        end
        else
            disc = sq + term;
        root = '0;
        for (int k = 43; k >= 0; k--)
        begin
            cand = root | (64'd1 << k);
            if ({64'b0, cand} * {64'b0, cand} <= disc)
                root = cand;
        end
        num = p + longint'(root);
        nmag = num < 0 ? -num : num;
        nmag = (nmag + a) / (2 * a);
        if (nmag > (64'd1 << 24))
            nmag = 64'd1 << 24;
        num = num < 0 ? -longint'(nmag) : longint'(nmag);
        if (num > 8388607)
            num = 8388607;
        if (num < -8388608)
            num = -8388608;
        res.energy = num[E_W-1:0];
        res.invalid = 1'b0;
        return res;
    endfunction

    task automatic apply_beat(pixel_beat_t bt);
        int idx;
        idx = int'(bt.row) * DEF_NUM_COLS + int'(bt.col);
        if (bt.op == OP_WRITE)
        begin
            slope_mem[idx] = bt.a;
            offset_mem[idx] = bt.b;
            curve_mem[idx] = bt.c;
            asym_mem[idx] = bt.t;
        end
        else
            energy_queue.push_back(calc_energy(idx, bt.tot));
    endtask

    function automatic pixel_beat_t make_write(int col, int row, int a, int b, int c, int t);
        pixel_beat_t bt;
        int idx;
        bt.op = OP_WRITE;
        bt.col = COL_W'(col);
        bt.row = ROW_W'(row);
        bt.tot = TOT_W'($urandom);
        bt.a = A_W'(a);
        bt.b = B_W'(b);
        bt.c = C_W'(c);
        bt.t = T_W'(t);
        idx = row * DEF_NUM_COLS + col;
        if (!written_seen.exists(idx))
        begin
            written_seen[idx] = 1'b1;
            written_pix.push_back(idx);
        end
        return bt;
    endfunction

    function automatic pixel_beat_t make_convert(int idx, int tot);
        pixel_beat_t bt;
        bt.op = OP_CONVERT;
        bt.col = COL_W'(idx % DEF_NUM_COLS);
        bt.row = ROW_W'(idx / DEF_NUM_COLS);
        bt.tot = TOT_W'(tot);
        bt.a = A_W'($urandom);
        bt.b = B_W'($urandom);
        bt.c = C_W'($urandom);
        bt.t = T_W'($urandom);
        return bt;
    endfunction

    // sender side
    always @(posedge clk or negedge rst_n)
    begin
        pixel_beat_t nxt;
        logic next_valid;
        int idle_pct;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                apply_beat(beat_queue.pop_front());
                beats_taken++;
                next_valid = 1'b0;
            end
            idle_pct = beats_taken < 700 ? 34 : (beats_taken < 1400 ? 58 : 0);
            if (!next_valid && beat_queue.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt = beat_queue[0];
                opcode <= nxt.op;
                pixel_col <= nxt.col;
                pixel_row <= nxt.row;
                tot_count <= nxt.tot;
                coef_a <= nxt.a;
                coef_b <= nxt.b;
                coef_c <= nxt.c;
                coef_t <= nxt.t;
                next_valid = 1'b1;
            end
            in_valid <= next_valid;
        end
    end

    // receiver side
    always @(posedge clk or negedge rst_n)
    begin
        energy_beat_t want;
        int idle_pct;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (energy_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: energy %0d invalid %0b",
                                 energy, invalid);
                end
                else
                begin
                    want = energy_queue.pop_front();
                    if (energy !== want.energy || invalid !== want.invalid)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: energy exp %0d got %0d, invalid exp %0b got %0b",
                                     want.energy, energy, want.invalid, invalid);
                    end
                end
            end
            if (!hold_done && beats_taken >= 300 && hold_count < 400)
            begin
                hold_count++;
                if (hold_count == 400)
                    hold_done = 1'b1;
                out_ready <= 1'b0;
            end
            else
            begin
                idle_pct = beats_taken < 700 ? 58 : (beats_taken < 1400 ? 34 : 0);
                out_ready <= $urandom_range(99) >= idle_pct;
            end
        end
    end

    initial
    begin
        int idx, col, row, a, b, c, t;
        // directed: extremes, zero slope, negative and zero discriminant
        beat_queue.push_back(make_write(0, 0, 24'h010000, 256, 0, 0));
        beat_queue.push_back(make_convert(0, 1));
        beat_queue.push_back(make_convert(0, 0));
        beat_queue.push_back(make_convert(0, 16383));
        beat_queue.push_back(make_write(511, 255, 24'hFFFFFF, 20'h7FFFF, 24'h7FFFFF, 16'h7FFF));
        beat_queue.push_back(make_convert(511 + 255 * DEF_NUM_COLS, 16383));
        beat_queue.push_back(make_convert(511 + 255 * DEF_NUM_COLS, 0));
        beat_queue.push_back(make_write(1, 0, 0, 100, 100, 100));
        beat_queue.push_back(make_convert(1, 5));
        beat_queue.push_back(make_write(2, 0, 24'h010000, 0, 24'h800000, 0));
        beat_queue.push_back(make_convert(2, 0));
        beat_queue.push_back(make_write(3, 0, 1, 20'h80000, 24'h800000, 16'h8000));
        beat_queue.push_back(make_convert(3, 16383));
        beat_queue.push_back(make_convert(3, 0));
        beat_queue.push_back(make_write(4, 1, 1, 20'h7FFFF, 24'h7FFFFF, 16'h7FFF));
        beat_queue.push_back(make_convert(4 + DEF_NUM_COLS, 0));
        beat_queue.push_back(make_write(5, 1, 24'h000200, 20'h80000, 24'h7FFFFF, 16'h8000));
        beat_queue.push_back(make_convert(5 + DEF_NUM_COLS, 8191));
        beat_queue.push_back(make_write(6, 2, 24'h020000, 20'h00A00, 24'h001000, 16'h0400));
        beat_queue.push_back(make_convert(6 + 2 * DEF_NUM_COLS, 40));
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (written_pix.size() == 0 || $urandom_range(99) < 35)
            begin
                if ($urandom_range(3) == 0)
                begin
                    col = $urandom_range(511);
                    row = $urandom_range(255);
                end
                else
                begin
                    col = $urandom_range(15);
                    row = $urandom_range(7);
                end
                if ($urandom_range(1))
                begin
                    a = $urandom;
                    b = $urandom;
                    c = $urandom;
                    t = $urandom;
                end
                else
                begin
                    a = $urandom_range(24'h0FFFFF, 24'h001000);
                    b = $urandom_range(4095) - 2048;
                    c = $urandom_range(65535) - 16384;
                    t = $urandom_range(8191) - 1024;
                end
                beat_queue.push_back(make_write(col, row, a, b, c, t));
            end
            else
            begin
                idx = written_pix[$urandom_range(written_pix.size() - 1)];
                beat_queue.push_back(make_convert(idx,
                    $urandom_range(1) ? $urandom_range(16383) : $urandom_range(255)));
            end
        end
        total_beats = beat_queue.size();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (beats_taken == total_beats);
        wait (energy_queue.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/pte_pkg.sv
src/pixel_tot_to_energy.sv
bench/tb_top.sv
